[src/hmq_pkg.sv]
// ----------------------------------------------------------------------------
// hmq_pkg: shared types and constants of the binary max-heap queue
// Holds the heap geometry, request and response payloads, result codes,
// sequencer states and the bundles that pass between the submodules.
// ----------------------------------------------------------------------------
package hmq_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = IDX_W + 1;

  typedef enum logic [1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_PEEK = 2'd2,
    MODE_REM  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOP,
    S_LAST,
    S_SEARCH,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_PICK,
    S_DN_CMP,
    S_RESP
  } state_e;

  typedef struct packed {
    mode_e              mode;
    logic [PRIO_W-1:0]  priority_req;
    logic [TAG_W-1:0]   data_tag;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [TAG_W-1:0]   tag_out;
    logic [PRIO_W-1:0]  priority_out;
    logic [CNT_W-1:0]   entry_count;
  } rsp_t;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // Heap storage access from the sequencer
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    entry_t             wdata;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

  // Results of the shared step unit
  typedef struct packed {
    logic               gt;
    logic [IDX_W-1:0]   parent;
    logic [IDX_W-1:0]   left;
    logic [IDX_W-1:0]   right;
    logic               left_ok;
    logic               right_ok;
  } step_t;

endpackage

[src/binary_max_heap_queue.sv]
// ----------------------------------------------------------------------------
// binary_max_heap_queue: priority queue on a binary max-heap
// Fixed-capacity heap of priority and tag pairs with enqueue, dequeue,
// peek and remove-by-tag; one response per request.
// ----------------------------------------------------------------------------
// The block takes one request at a time and deasserts in_ready_o while it
// works; every step reads or writes the heap memory, whose read data is
// registered, so latency follows the tree depth. Empty or full answers go
// straight to the response. Enqueue climbs the tree and dequeue descends
// it one level at a time. Remove scans the heap one slot a cycle and then
// re-sifts like enqueue or dequeue. The input reopens as the response is
// loaded into the output register. The response sits in an output
// register, so the next request is taken while it waits to be transferred.
// Storage needs no initialization after reset.
module binary_max_heap_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hmq_pkg::req_t   in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output hmq_pkg::rsp_t   out_rsp_o
);

  hmq_pkg::mem_req_t mem_req;
  hmq_pkg::entry_t   mem_rdata;
  hmq_pkg::rsp_t     rsp, out_rsp_q;
  logic              rsp_valid, slot_free;
  logic              out_valid_q, out_valid_d;

  hmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_req_i),
    .rsp_valid_o (rsp_valid),
    .slot_free_i (slot_free),
    .rsp_o       (rsp),
    .mem_o       (mem_req),
    .rdata_i     (mem_rdata)
  );

  hmq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_valid && slot_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && slot_free) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

[src/hmq_ram.sv]
// ----------------------------------------------------------------------------
// hmq_ram: heap entry storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module hmq_ram (
  input  logic                clk_i,
  input  hmq_pkg::mem_req_t   req_i,
  output hmq_pkg::entry_t     rdata_o
);

  hmq_pkg::entry_t mem [hmq_pkg::CAPACITY];
  hmq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

[src/hmq_step.sv]
// ----------------------------------------------------------------------------
// hmq_step: shared compare and index unit
// Compares two priorities and derives parent and child slots of a position,
// with range checks of the children against the entry count.
// ----------------------------------------------------------------------------
module hmq_step (
  input  logic [hmq_pkg::IDX_W-1:0]  pos_i,
  input  logic [hmq_pkg::CNT_W-1:0]  count_i,
  input  logic [hmq_pkg::PRIO_W-1:0] a_i,
  input  logic [hmq_pkg::PRIO_W-1:0] b_i,
  output hmq_pkg::step_t             step_o
);

  localparam int unsigned IdxW = hmq_pkg::IDX_W;
  localparam int unsigned WideW = hmq_pkg::IDX_W + 2;

  logic [WideW-1:0] left_w;
  logic [WideW-1:0] right_w;
  logic [WideW-1:0] count_w;
  logic [IdxW-1:0]  pos_m1;

  assign left_w  = {1'b0, pos_i, 1'b1};
  assign right_w = left_w + WideW'(1);
  assign count_w = WideW'(count_i);
  assign pos_m1  = pos_i - IdxW'(1);

  assign step_o.gt       = a_i > b_i;
  assign step_o.parent   = pos_m1 >> 1;
  assign step_o.left     = left_w[IdxW-1:0];
  assign step_o.right    = right_w[IdxW-1:0];
  assign step_o.left_ok  = left_w < count_w;
  assign step_o.right_ok = right_w < count_w;

endmodule

[src/hmq_ctrl.sv]
// ----------------------------------------------------------------------------
// hmq_ctrl: heap operation sequencer
// Runs enqueue, dequeue, peek and remove as a walk over the heap memory,
// carrying the moving entry in a register and writing each slot once.
// ----------------------------------------------------------------------------
module hmq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  hmq_pkg::req_t       req_i,
  output logic                rsp_valid_o,
  input  logic                slot_free_i,
  output hmq_pkg::rsp_t       rsp_o,
  output hmq_pkg::mem_req_t   mem_o,
  input  hmq_pkg::entry_t     rdata_i
);

  localparam int unsigned IdxW = hmq_pkg::IDX_W;
  localparam int unsigned CntW = hmq_pkg::CNT_W;
  localparam logic [CntW-1:0] FullCnt = CntW'(hmq_pkg::CAPACITY);

  hmq_pkg::state_e  state_q, state_d;
  hmq_pkg::mode_e   op_q, op_d;
  hmq_pkg::status_e status_q, status_d;
  hmq_pkg::entry_t  x_q, x_d;
  hmq_pkg::entry_t  child_q, child_d;
  hmq_pkg::entry_t  res_q, res_d;
  logic [IdxW-1:0]  pos_q, pos_d;
  logic [IdxW-1:0]  pick_q, pick_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  scan_q, scan_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic             moved_q, moved_d;

  logic [hmq_pkg::PRIO_W-1:0] cmp_a, cmp_b;
  hmq_pkg::step_t   step;
  logic             accept;
  logic             full, empty, hit, scan_done, rem_first;
  logic [CntW-1:0]  count_m1;

  hmq_step u_step (
    .pos_i   (pos_q),
    .count_i (count_q),
    .a_i     (cmp_a),
    .b_i     (cmp_b),
    .step_o  (step)
  );

  assign accept    = req_valid_i && (state_q == hmq_pkg::S_IDLE);
  assign full      = count_q == FullCnt;
  assign empty     = count_q == '0;
  assign count_m1  = count_q - CntW'(1);
  assign hit       = cmp_vld_q && (rdata_i.tag == x_q.tag);
  assign scan_done = scan_q == count_q;
  assign rem_first = (op_q == hmq_pkg::MODE_REM) && !moved_q;

  // Route operands to the shared comparator
  always_comb begin
    case (state_q)
      hmq_pkg::S_UP_CMP: begin
        cmp_a = x_q.prio;
        cmp_b = rdata_i.prio;
      end
      hmq_pkg::S_DN_PICK: begin
        cmp_a = child_q.prio;
        cmp_b = rdata_i.prio;
      end
      default: begin
        cmp_a = child_q.prio;
        cmp_b = x_q.prio;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hmq_pkg::S_IDLE: begin
        if (accept) begin
          case (req_i.mode)
            hmq_pkg::MODE_ENQ:  state_d = full ? hmq_pkg::S_RESP : hmq_pkg::S_UP_RD;
            hmq_pkg::MODE_REM:  state_d = empty ? hmq_pkg::S_RESP : hmq_pkg::S_SEARCH;
            default:            state_d = empty ? hmq_pkg::S_RESP : hmq_pkg::S_TOP;
          endcase
        end
      end
      hmq_pkg::S_TOP: begin
        if (op_q == hmq_pkg::MODE_PEEK || count_q == CntW'(1)) begin
          state_d = hmq_pkg::S_RESP;
        end else begin
          state_d = hmq_pkg::S_LAST;
        end
      end
      hmq_pkg::S_LAST: begin
        state_d = (op_q == hmq_pkg::MODE_DEQ) ? hmq_pkg::S_DN_RDL : hmq_pkg::S_UP_RD;
      end
      hmq_pkg::S_SEARCH: begin
        if (hit) begin
          state_d = scan_done ? hmq_pkg::S_RESP : hmq_pkg::S_LAST;
        end else if (scan_done) begin
          state_d = hmq_pkg::S_RESP;
        end
      end
      hmq_pkg::S_UP_RD: begin
        if (pos_q != '0) begin
          state_d = hmq_pkg::S_UP_CMP;
        end else begin
          state_d = rem_first ? hmq_pkg::S_DN_RDL : hmq_pkg::S_RESP;
        end
      end
      hmq_pkg::S_UP_CMP: begin
        if (step.gt) begin
          state_d = hmq_pkg::S_UP_RD;
        end else begin
          state_d = rem_first ? hmq_pkg::S_DN_RDL : hmq_pkg::S_RESP;
        end
      end
      hmq_pkg::S_DN_RDL: begin
        state_d = step.left_ok ? hmq_pkg::S_DN_RDR : hmq_pkg::S_RESP;
      end
      hmq_pkg::S_DN_RDR: begin
        state_d = step.right_ok ? hmq_pkg::S_DN_PICK : hmq_pkg::S_DN_CMP;
      end
      hmq_pkg::S_DN_PICK: begin
        state_d = hmq_pkg::S_DN_CMP;
      end
      hmq_pkg::S_DN_CMP: begin
        state_d = step.gt ? hmq_pkg::S_DN_RDL : hmq_pkg::S_RESP;
      end
      hmq_pkg::S_RESP: begin
        if (slot_free_i) begin
          state_d = hmq_pkg::S_IDLE;
        end
      end
      default: state_d = hmq_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    op_d      = op_q;
    status_d  = status_q;
    x_d       = x_q;
    child_d   = child_q;
    res_d     = res_q;
    pos_d     = pos_q;
    pick_d    = pick_q;
    count_d   = count_q;
    scan_d    = scan_q;
    cmp_vld_d = cmp_vld_q;
    moved_d   = moved_q;
    mem_o     = '0;

    case (state_q)
      hmq_pkg::S_IDLE: begin
        if (accept) begin
          op_d      = req_i.mode;
          x_d       = '{prio: req_i.priority_req, tag: req_i.data_tag};
          res_d     = '0;
          status_d  = hmq_pkg::ST_OK;
          moved_d   = 1'b0;
          scan_d    = '0;
          cmp_vld_d = 1'b0;
          pos_d     = '0;
          case (req_i.mode)
            hmq_pkg::MODE_ENQ: begin
              if (full) begin
                status_d = hmq_pkg::ST_FULL;
              end else begin
                pos_d   = count_q[IdxW-1:0];
                count_d = count_q + CntW'(1);
              end
            end
            default: begin
              if (empty) begin
                status_d = hmq_pkg::ST_EMPTY;
              end
            end
          endcase
        end
      end
      hmq_pkg::S_TOP: begin
        res_d = rdata_i;
        if (op_q == hmq_pkg::MODE_DEQ) begin
          count_d     = count_m1;
          mem_o.raddr = count_m1[IdxW-1:0];
        end
      end
      hmq_pkg::S_LAST: begin
        x_d     = rdata_i;
        moved_d = 1'b0;
      end
      hmq_pkg::S_SEARCH: begin
        if (hit) begin
          pos_d       = IdxW'(scan_q - CntW'(1));
          count_d     = count_m1;
          mem_o.raddr = count_m1[IdxW-1:0];
        end else if (scan_done) begin
          status_d = hmq_pkg::ST_NOT_FOUND;
        end else begin
          mem_o.raddr = scan_q[IdxW-1:0];
          scan_d      = scan_q + CntW'(1);
          cmp_vld_d   = 1'b1;
        end
      end
      hmq_pkg::S_UP_RD: begin
        if (pos_q != '0) begin
          mem_o.raddr = step.parent;
        end else if (!rem_first) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = pos_q;
          mem_o.wdata = x_q;
        end
      end
      hmq_pkg::S_UP_CMP: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = pos_q;
        if (step.gt) begin
          // pull the parent down into the hole and climb
          mem_o.wdata = rdata_i;
          pos_d       = step.parent;
          moved_d     = 1'b1;
        end else begin
          mem_o.we    = !rem_first;
          mem_o.wdata = x_q;
        end
      end
      hmq_pkg::S_DN_RDL: begin
        if (step.left_ok) begin
          mem_o.raddr = step.left;
        end else begin
          mem_o.we    = 1'b1;
          mem_o.waddr = pos_q;
          mem_o.wdata = x_q;
        end
      end
      hmq_pkg::S_DN_RDR: begin
        child_d     = rdata_i;
        pick_d      = step.left;
        mem_o.raddr = step.right;
      end
      hmq_pkg::S_DN_PICK: begin
        // right child wins unless left is strictly larger
        if (!step.gt) begin
          child_d = rdata_i;
          pick_d  = step.right;
        end
      end
      hmq_pkg::S_DN_CMP: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = pos_q;
        if (step.gt) begin
          mem_o.wdata = child_q;
          pos_d       = pick_q;
        end else begin
          mem_o.wdata = x_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hmq_pkg::S_IDLE;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
      moved_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
      moved_q   <= moved_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    status_q <= status_d;
    x_q      <= x_d;
    child_q  <= child_d;
    res_q    <= res_d;
    pos_q    <= pos_d;
    pick_q   <= pick_d;
    scan_q   <= scan_d;
  end

  assign req_ready_o = state_q == hmq_pkg::S_IDLE;
  assign rsp_valid_o = state_q == hmq_pkg::S_RESP;

  always_comb begin
    rsp_o.status       = status_q;
    rsp_o.tag_out      = res_q.tag;
    rsp_o.priority_out = res_q.prio;
    rsp_o.entry_count  = count_q;
  end

endmodule

[src/hmq_checker.sv]
// ----------------------------------------------------------------------------
// hmq_checker: port-level checks of the heap queue
// Watches the request and response channels and flags illegal behavior.
// ----------------------------------------------------------------------------
module hmq_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_o,
  input  logic            out_valid_o,
  input  logic            out_ready_i,
  input  hmq_pkg::rsp_t   out_rsp_o
);

  localparam int unsigned CntW = hmq_pkg::CNT_W;
  localparam logic [CntW-1:0] FullCnt = CntW'(hmq_pkg::CAPACITY);

  // One request in flight: a transfer closes the input for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again right after a transfer");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == hmq_pkg::ST_EMPTY |->
      out_rsp_o.entry_count == '0 && out_rsp_o.tag_out == '0 &&
      out_rsp_o.priority_out == '0)
    else $error("empty response with data or nonzero count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == hmq_pkg::ST_FULL |->
      out_rsp_o.entry_count == FullCnt)
    else $error("full response below capacity");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.entry_count <= FullCnt)
    else $error("entry count above capacity");

endmodule

bind binary_max_heap_queue hmq_checker u_hmq_checker (.*);
